// ===== design/rrsr_pkg.sv =====
package rrsr_pkg;

  // Result count fields are fixed at 11 bits
  localparam int CNT_W = 11;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_NEXT   = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] entry_x;
    logic signed [31:0] entry_y;
    logic [CNT_W-1:0]   removed_count;
    logic [CNT_W-1:0]   occupancy;
    logic [1:0]         status;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FIN
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic exec;
    logic scan;
    logic finish;
  } cmd_t;

endpackage

// ===== design/round_robin_scan_ring.sv =====
// Round-robin scan ring. A word is taken at a clock edge with start high and
// busy low; its result shows on result for exactly one cycle with done high,
// and the receiver cannot stall it, so it must take every done cycle.
// Append, next and the unused op code pass through one execute state. Remove
// walks the stored entries through the single read port of the ring memory,
// one entry a cycle, and then passes through a wrap-up state. A new
// word may be started in the cycle its predecessor's result is shown.
// Ring contents are not cleared at reset; only entries below the size are
// ever used.
module round_robin_scan_ring #(
  parameter int RING_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  rrsr_pkg::in_word_t  cmd,
  output logic                busy,
  output logic                done,
  output rrsr_pkg::out_word_t result
);

  rrsr_pkg::cmd_t ctl;      // controller commands
  logic           scan_done; // remove walk finished

  // Sequencer: idle, single-step execute, remove walk, remove wrap-up.
  rrsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .op        (cmd.op),
    .scan_done (scan_done),
    .busy      (busy),
    .ctl       (ctl)
  );

  // Ring memory, size and cursor registers, compaction pipe, result register.
  rrsr_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .cmd       (cmd),
    .scan_done (scan_done),
    .done      (done),
    .result    (result)
  );

endmodule

// ===== design/rrsr_ctrl.sv =====
module rrsr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        op,
  input  logic              scan_done,
  output logic              busy,
  output rrsr_pkg::cmd_t    ctl
);

  rrsr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrsr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rrsr_pkg::S_IDLE: begin
        if (start) begin
          state_next = (op == rrsr_pkg::OP_REMOVE) ? rrsr_pkg::S_SCAN : rrsr_pkg::S_EXEC;
        end
      end
      rrsr_pkg::S_EXEC: state_next = rrsr_pkg::S_IDLE;
      rrsr_pkg::S_SCAN: begin
        if (scan_done) begin
          state_next = rrsr_pkg::S_FIN;
        end
      end
      rrsr_pkg::S_FIN: state_next = rrsr_pkg::S_IDLE;
      default: state_next = rrsr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy       = 1'b1;
    ctl        = '0;
    case (state)
      rrsr_pkg::S_IDLE: begin
        busy       = 1'b0;
        ctl.accept = start;
      end
      rrsr_pkg::S_EXEC: ctl.exec   = 1'b1;
      rrsr_pkg::S_SCAN: ctl.scan   = 1'b1;
      rrsr_pkg::S_FIN:  ctl.finish = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

// ===== design/rrsr_datapath.sv =====
module rrsr_datapath #(
  parameter int RING_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  rrsr_pkg::cmd_t      ctl,
  input  rrsr_pkg::in_word_t  cmd,
  output logic                scan_done,
  output logic                done,
  output rrsr_pkg::out_word_t result
);

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int RW = rrsr_pkg::CNT_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);

  // ring storage: one write port, one registered read port
  rrsr_pkg::entry_t mem [RING_DEPTH];
  rrsr_pkg::entry_t rdata;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr;
  rrsr_pkg::entry_t wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  rrsr_pkg::entry_t    key;
  logic [1:0]          op_q;
  logic [CW-1:0]       count, count_next;
  logic [AW-1:0]       cursor, cursor_next;
  logic [CW-1:0]       rd_ptr, rd_ptr_next;
  logic [CW-1:0]       wr_ptr, wr_ptr_next;
  logic [CW-1:0]       ahead_hits, ahead_hits_next;
  logic                pend_valid, pend_valid_next;
  logic [AW-1:0]       pend_idx, pend_idx_next;
  rrsr_pkg::out_word_t result_next;
  logic [CW-1:0]       cur_ext;
  logic [CW-1:0]       cur_inc;
  logic [CW-1:0]       cur_diff;
  logic [CW-1:0]       removed;
  logic                rd_more;

  assign cur_ext   = CW'(cursor);
  assign cur_inc   = cur_ext + CW'(1);
  assign cur_diff  = cur_ext - ahead_hits;
  assign removed   = count - wr_ptr;
  assign rd_more   = (rd_ptr != count);
  assign scan_done = !rd_more && !pend_valid;
  assign raddr     = ctl.scan ? rd_ptr[AW-1:0] : cursor;

  always_comb begin
    we              = 1'b0;
    waddr           = count[AW-1:0];
    wdata           = key;
    count_next      = count;
    cursor_next     = cursor;
    rd_ptr_next     = rd_ptr;
    wr_ptr_next     = wr_ptr;
    ahead_hits_next = ahead_hits;
    pend_valid_next = pend_valid;
    pend_idx_next   = pend_idx;
    result_next     = '0;

    if (ctl.accept) begin
      rd_ptr_next     = '0;
      wr_ptr_next     = '0;
      ahead_hits_next = '0;
      pend_valid_next = 1'b0;
    end

    if (ctl.exec) begin
      case (op_q)
        rrsr_pkg::OP_APPEND: begin
          if (count == DEPTH_C) begin
            result_next.status = rrsr_pkg::STAT_FULL;
          end else begin
            we         = 1'b1;
            count_next = count + CW'(1);
          end
        end
        rrsr_pkg::OP_NEXT: begin
          if (count == '0) begin
            result_next.status = rrsr_pkg::STAT_EMPTY;
          end else begin
            result_next.entry_x = rdata.x;
            result_next.entry_y = rdata.y;
            cursor_next = (cur_inc == count) ? '0 : cur_inc[AW-1:0];
          end
        end
        default: result_next.status = rrsr_pkg::STAT_OK;
      endcase
      result_next.occupancy = RW'(count_next);
    end

    if (ctl.scan) begin
      // stage 1: fetch next entry
      pend_valid_next = rd_more;
      pend_idx_next   = rd_ptr[AW-1:0];
      if (rd_more) begin
        rd_ptr_next = rd_ptr + CW'(1);
      end
      // stage 2: compact survivors, count matches ahead of the cursor
      if (pend_valid) begin
        if (rdata == key) begin
          if (pend_idx < cursor) begin
            ahead_hits_next = ahead_hits + CW'(1);
          end
        end else begin
          we          = 1'b1;
          waddr       = wr_ptr[AW-1:0];
          wdata       = rdata;
          wr_ptr_next = wr_ptr + CW'(1);
        end
      end
    end

    if (ctl.finish) begin
      if (removed != '0) begin
        count_next = wr_ptr;
        if (wr_ptr == '0 || ahead_hits >= cur_ext || cur_diff >= wr_ptr) begin
          cursor_next = '0;
        end else begin
          cursor_next = cur_diff[AW-1:0];
        end
      end
      result_next.removed_count = RW'(removed);
      result_next.occupancy     = RW'(count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      cursor     <= '0;
      pend_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      count      <= count_next;
      cursor     <= cursor_next;
      pend_valid <= pend_valid_next;
      done       <= ctl.exec | ctl.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      key  <= '{x: cmd.coord_x, y: cmd.coord_y};
      op_q <= cmd.op;
    end
    rd_ptr     <= rd_ptr_next;
    wr_ptr     <= wr_ptr_next;
    ahead_hits <= ahead_hits_next;
    pend_idx   <= pend_idx_next;
    result     <= result_next;
  end

endmodule
